>>> rtl/tup_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// Texture upload texel packer package
// Field widths, register indexes and source pixel formats shared by the
// packer, its pack stage and its channel interfaces.
// ---------------------------------------------------------------------------
package tup_pkg;

  localparam int ByteW    = 8;
  localparam int TexelW   = 16;
  localparam int IndexW   = 20;
  localparam int WordW    = 32;
  localparam int HeldW    = 24;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 4;
  localparam int FmtW     = 2;
  localparam int Log2W    = 4;
  localparam int AlignW   = 4;

  localparam logic [AlignW-1:0] AlignReset = 4'd4;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PIXEL_FORMAT  = 2'd0,
    CFG_WIDTH_LOG2    = 2'd1,
    CFG_HEIGHT_LOG2   = 2'd2,
    CFG_ROW_ALIGNMENT = 2'd3
  } cfg_reg_e;

  typedef enum logic [FmtW-1:0] {
    FMT_RGB888   = 2'd0,
    FMT_RGB565   = 2'd1,
    FMT_RGBA8888 = 2'd2,
    FMT_RGBA5551 = 2'd3
  } pixel_format_e;

endpackage : tup_pkg
`default_nettype wire

>>> rtl/tup_byte_if.sv
`default_nettype none
// ---------------------------------------------------------------------------
// Byte channel
// Valid/ready channel carrying one byte of client pixel data per beat.
// ---------------------------------------------------------------------------
interface tup_byte_if;
  logic                      valid;
  logic                      ready;
  logic [tup_pkg::ByteW-1:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface : tup_byte_if
`default_nettype wire

>>> rtl/tup_texel_if.sv
`default_nettype none
// ---------------------------------------------------------------------------
// Texel channel
// Valid/ready channel carrying one packed texel, its index and the
// end-of-image flag per beat.
// ---------------------------------------------------------------------------
interface tup_texel_if;
  logic                       valid;
  logic                       ready;
  logic [tup_pkg::TexelW-1:0] texel;
  logic [tup_pkg::IndexW-1:0] texel_index;
  logic                       last_texel;

  modport source (output valid, output texel, output texel_index, output last_texel,
                  input ready);
  modport sink   (input valid, input texel, input texel_index, input last_texel,
                  output ready);
endinterface : tup_texel_if
`default_nettype wire

>>> rtl/tup_pack.sv
`default_nettype none
// ---------------------------------------------------------------------------
// Texel pack stage
// Slices a gathered source pixel into the 5-6-5 or R5 G5 A1 B5 texel layout.
// ---------------------------------------------------------------------------
module tup_pack (
  input  var tup_pkg::pixel_format_e        fmt_i,
  input  var logic [tup_pkg::WordW-1:0]     word_i,
  output var logic [tup_pkg::TexelW-1:0]    texel_o
);

  logic [7:0]  b0, b1, b2, b3;
  logic [15:0] p;

  assign b0 = word_i[7:0];
  assign b1 = word_i[15:8];
  assign b2 = word_i[23:16];
  assign b3 = word_i[31:24];
  assign p  = word_i[15:0];

  always_comb begin
    unique case (fmt_i)
      tup_pkg::FMT_RGB888:   texel_o = {b0[7:3], b1[7:2], b2[7:3]};
      tup_pkg::FMT_RGB565:   texel_o = p;
      // Alpha takes the top bit of the fourth byte and sits between G and B.
      tup_pkg::FMT_RGBA8888: texel_o = {b0[7:3], b1[7:3], b3[7], b2[7:3]};
      tup_pkg::FMT_RGBA5551: texel_o = {p[15:11], p[10:6], p[0], p[5:1]};
      default:               texel_o = p;
    endcase
  end

endmodule : tup_pack
`default_nettype wire

>>> rtl/texture_upload_texel_packer_unit.sv
`default_nettype none
// ---------------------------------------------------------------------------
// Texture upload texel packer
// Packs client pixel bytes into 16-bit texels, skipping row padding, and
// tags each texel with its row-major index and an end-of-image flag.
// ---------------------------------------------------------------------------
// Path: a texel is packed from the input register into the texel register.
// Throughput: one byte per cycle; the input register and the texel register
// both move on whenever the texel register is empty or being taken.
// Reset: clears configuration to its defaults (alignment of four), all
// counters, the held bytes and both valid flags. A configuration write
// restarts the image.
module texture_upload_texel_packer_unit #(
  parameter int MAX_SIZE_LOG2 = 10
) (
  input  var logic                          clk_i,
  input  var logic                          rst_ni,
  input  var logic                          cfg_we_i,
  input  var logic [tup_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  var logic [tup_pkg::CfgDataW-1:0]  cfg_data_i,
  tup_byte_if.sink                          byte_i,
  tup_texel_if.source                       texel_o
);

  localparam int CntW = MAX_SIZE_LOG2 + 1;
  localparam int RbcW = MAX_SIZE_LOG2 + 3;
  localparam int IdxW = (2 * CntW > tup_pkg::IndexW) ? 2 * CntW : tup_pkg::IndexW;
  localparam logic [tup_pkg::Log2W-1:0] MaxLog2 = tup_pkg::Log2W'(MAX_SIZE_LOG2);

  // Configuration
  tup_pkg::pixel_format_e           fmt_q;
  logic [tup_pkg::Log2W-1:0]        wl_q, hl_q;
  logic [tup_pkg::AlignW-1:0]       align_q;

  // Image walk state
  logic [1:0]                       phase_q, phase_d;
  logic [tup_pkg::HeldW-1:0]        held_q, held_d;
  logic [RbcW-1:0]                  rbc_q, rbc_d;
  logic [tup_pkg::AlignW-1:0]       acnt_q, acnt_d;
  logic [CntW-1:0]                  col_q, col_d;
  logic [CntW-1:0]                  row_q, row_d;

  // Pipeline registers
  logic                             in_valid_q;
  logic [tup_pkg::ByteW-1:0]        byte_q;
  logic                             out_valid_q;
  logic [tup_pkg::TexelW-1:0]       texel_q;
  logic [tup_pkg::IndexW-1:0]       index_q;
  logic                             last_q;

  logic                             advance, in_ready, s1_fire;
  logic [tup_pkg::Log2W-1:0]        wl_c, hl_c;
  logic [CntW-1:0]                  width_w, height_w;
  logic [RbcW-1:0]                  w_bytes, data_bytes, rbc_inc;
  logic [2:0]                       bpp;
  logic [tup_pkg::AlignW-1:0]       align_eff;
  logic                             in_data, complete, last, row_end, emit;
  logic [tup_pkg::WordW-1:0]        word;
  logic [tup_pkg::TexelW-1:0]       texel_d;
  logic [IdxW-1:0]                  idx_full;

  assign advance  = !out_valid_q || texel_o.ready;
  assign in_ready = !in_valid_q || advance;
  assign s1_fire  = in_valid_q && advance;
  assign byte_i.ready = in_ready;

  // Derived image geometry
  assign wl_c     = (wl_q > MaxLog2) ? MaxLog2 : wl_q;
  assign hl_c     = (hl_q > MaxLog2) ? MaxLog2 : hl_q;
  assign width_w  = CntW'(1) << wl_c;
  assign height_w = CntW'(1) << hl_c;
  assign w_bytes  = RbcW'(1) << wl_c;
  assign align_eff = (align_q == '0) ? tup_pkg::AlignW'(1) : align_q;

  always_comb begin
    unique case (fmt_q)
      tup_pkg::FMT_RGB888: begin
        bpp        = 3'd3;
        data_bytes = (w_bytes << 1) + w_bytes;
      end
      tup_pkg::FMT_RGBA8888: begin
        bpp        = 3'd4;
        data_bytes = w_bytes << 2;
      end
      default: begin
        bpp        = 3'd2;
        data_bytes = w_bytes << 1;
      end
    endcase
  end

  assign word = {8'd0, held_q} | (tup_pkg::WordW'(byte_q) << {phase_q, 3'b000});

  tup_pack u_pack (
    .fmt_i   (fmt_q),
    .word_i  (word),
    .texel_o (texel_d)
  );

  assign idx_full = (IdxW'(row_q) << wl_c) + IdxW'(col_q);

  assign in_data  = rbc_q < data_bytes;
  assign complete = in_data && ((3'(phase_q) + 3'd1) >= bpp);
  assign last     = ((col_q + 1'b1) >= width_w) && ((row_q + 1'b1) >= height_w);
  assign emit     = complete;
  assign rbc_inc  = rbc_q + 1'b1;
  // The padded row ends at the first multiple of the alignment at or past
  // the data bytes; the alignment counter tracks that multiple.
  assign row_end  = (rbc_inc >= data_bytes) && ((acnt_q + 1'b1) == align_eff);

  always_comb begin
    phase_d = phase_q;
    held_d  = held_q;
    rbc_d   = rbc_q;
    acnt_d  = acnt_q;
    col_d   = col_q;
    row_d   = row_q;
    if (cfg_we_i) begin
      phase_d = '0;
      held_d  = '0;
      rbc_d   = '0;
      acnt_d  = '0;
      col_d   = '0;
      row_d   = '0;
    end else if (s1_fire) begin
      if (complete && last) begin
        // End of image: everything restarts and trailing padding is not consumed.
        phase_d = '0;
        held_d  = '0;
        rbc_d   = '0;
        acnt_d  = '0;
        col_d   = '0;
        row_d   = '0;
      end else begin
        if (complete) begin
          phase_d = '0;
          held_d  = '0;
          col_d   = col_q + 1'b1;
        end else if (in_data) begin
          held_d  = word[tup_pkg::HeldW-1:0];
          phase_d = phase_q + 1'b1;
        end
        if (row_end) begin
          rbc_d   = '0;
          acnt_d  = '0;
          col_d   = '0;
          phase_d = '0;
          held_d  = '0;
          row_d   = ((row_q + 1'b1) >= height_w) ? '0 : row_q + 1'b1;
        end else begin
          rbc_d   = rbc_inc;
          // The alignment counter holds the row byte position modulo the alignment.
          acnt_d  = ((acnt_q + 1'b1) == align_eff) ? '0 : acnt_q + 1'b1;
        end
      end
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q   <= tup_pkg::FMT_RGB888;
      wl_q    <= '0;
      hl_q    <= '0;
      align_q <= tup_pkg::AlignReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tup_pkg::CFG_PIXEL_FORMAT:  fmt_q   <= tup_pkg::pixel_format_e'(
                                                 cfg_data_i[tup_pkg::FmtW-1:0]);
        tup_pkg::CFG_WIDTH_LOG2:    wl_q    <= cfg_data_i;
        tup_pkg::CFG_HEIGHT_LOG2:   hl_q    <= cfg_data_i;
        tup_pkg::CFG_ROW_ALIGNMENT: align_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Walk state and valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= '0;
      held_q      <= '0;
      rbc_q       <= '0;
      acnt_q      <= '0;
      col_q       <= '0;
      row_q       <= '0;
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      held_q  <= held_d;
      rbc_q   <= rbc_d;
      acnt_q  <= acnt_d;
      col_q   <= col_d;
      row_q   <= row_d;
      if (byte_i.valid && in_ready) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= s1_fire && emit;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (byte_i.valid && in_ready) begin
      byte_q <= byte_i.data_byte;
    end
    if (s1_fire && emit) begin
      texel_q <= texel_d;
      index_q <= idx_full[tup_pkg::IndexW-1:0];
      last_q  <= last;
    end
  end

  assign texel_o.valid       = out_valid_q;
  assign texel_o.texel       = texel_q;
  assign texel_o.texel_index = index_q;
  assign texel_o.last_texel  = last_q;

`ifndef NO_ASSERTIONS
  // After the final texel of an image the walk starts again from the origin.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && emit && last |=> (row_q == '0) && (col_q == '0) && (rbc_q == '0))
    else $error("walk state not cleared after last texel");

  // The byte phase never reaches the pixel size of the current format.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (3'(phase_q) < bpp))
    else $error("byte phase beyond pixel size");

  // The alignment counter stays below the effective alignment.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acnt_q < align_eff))
    else $error("alignment counter out of range");

  // A held input beat is neither dropped nor overwritten while the output stalls.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(byte_q))
    else $error("input register lost a beat");
`endif

endmodule : texture_upload_texel_packer_unit
`default_nettype wire

>>> bench/texture_upload_texel_packer_unit_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Texel packer testbench
// Streams client pixel bytes into the packer under every source format and
// row alignment and a range of image sizes, predicts each packed texel
// with its index and end-of-image flag, and checks every texel beat in
// order while both channels idle and stall at random.
// ---------------------------------------------------------------------------
module texture_upload_texel_packer_unit_tb;

  localparam int MaxSizeLog2  = 10;
  localparam int SettleCycles = 8;
  localparam int CycleLimit   = 1000000;
  localparam int RandomItems  = 1000;

  typedef struct packed {
    logic [tup_pkg::TexelW-1:0] texel;
    logic [tup_pkg::IndexW-1:0] index;
    logic                       last;
  } texel_beat_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [tup_pkg::CfgIdxW-1:0] cfg_idx_i;
  logic [tup_pkg::CfgDataW-1:0] cfg_data_i;

  tup_byte_if  byte_if ();
  tup_texel_if texel_if ();

  texture_upload_texel_packer_unit #(
    .MAX_SIZE_LOG2(MaxSizeLog2)
  ) uut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .byte_i    (byte_if),
    .texel_o   (texel_if)
  );

  // Predicted packer state and configuration.
  tup_pkg::pixel_format_e     fmt_q;
  logic [tup_pkg::Log2W-1:0]  wlog_q;
  logic [tup_pkg::Log2W-1:0]  hlog_q;
  logic [tup_pkg::AlignW-1:0] align_q;
  logic [1:0]                 phase_q;
  logic [tup_pkg::HeldW-1:0]  held_q;
  logic [12:0]                row_byte_q;
  logic [10:0]                col_q;
  logic [10:0]                row_q;

  texel_beat_t pending_texels[$];
  int          mismatch_count = 0;
  int          cycle_count = 0;
  int          hold_cycles_left = 0;
  bit          steady_flow = 1'b0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("texture_upload_texel_packer_unit_tb failed");
      $finish;
    end
  end

  function automatic int unsigned width_texels();
    return 1 << ((wlog_q > MaxSizeLog2) ? MaxSizeLog2 : wlog_q);
  endfunction

  function automatic int unsigned height_texels();
    return 1 << ((hlog_q > MaxSizeLog2) ? MaxSizeLog2 : hlog_q);
  endfunction

  function automatic int unsigned bytes_per_pixel();
    case (fmt_q)
      tup_pkg::FMT_RGB888:   return 3;
      tup_pkg::FMT_RGBA8888: return 4;
      default:               return 2;
    endcase
  endfunction

  function automatic int unsigned padded_row_bytes();
    int unsigned align;
    int unsigned data_bytes;
    align = (align_q == 0) ? 1 : align_q;
    data_bytes = width_texels() * bytes_per_pixel();
    return ((data_bytes + align - 1) / align) * align;
  endfunction

  // The padding of the final row is never sent.
  function automatic int unsigned image_bytes();
    return (height_texels() - 1) * padded_row_bytes() + width_texels() * bytes_per_pixel();
  endfunction

  function automatic logic [tup_pkg::TexelW-1:0] packed_texel_of(
      tup_pkg::pixel_format_e fmt, logic [tup_pkg::WordW-1:0] word);
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
    logic [15:0] p;
    b0 = word[7:0];
    b1 = word[15:8];
    b2 = word[23:16];
    b3 = word[31:24];
    p  = word[15:0];
    case (fmt)
      tup_pkg::FMT_RGB888:   return {b0[7:3], b1[7:2], b2[7:3]};
      tup_pkg::FMT_RGB565:   return p;
      tup_pkg::FMT_RGBA8888: return {b0[7:3], b1[7:3], b3[7], b2[7:3]};
      default:               return {p[15:11], p[10:6], p[0], p[5:1]};
    endcase
  endfunction

  function automatic void restart_image();
    phase_q    = '0;
    held_q     = '0;
    row_byte_q = '0;
    col_q      = '0;
    row_q      = '0;
  endfunction

  function automatic void advance_packer(logic [tup_pkg::ByteW-1:0] value);
    int unsigned width;
    int unsigned height;
    int unsigned bpp;
    logic [tup_pkg::WordW-1:0] word;
    logic last;
    texel_beat_t beat;
    width  = width_texels();
    height = height_texels();
    bpp    = bytes_per_pixel();
    if (row_byte_q < width * bpp) begin
      if (int'(phase_q) + 1 >= bpp) begin
        word = {8'h00, held_q} | (tup_pkg::WordW'(value) << (8 * phase_q));
        last = (col_q + 1 >= width) && (row_q + 1 >= height);
        beat.texel = packed_texel_of(fmt_q, word);
        beat.index = tup_pkg::IndexW'(row_q * width + col_q);
        beat.last  = last;
        pending_texels = {pending_texels, beat};
        phase_q = '0;
        held_q  = '0;
        if (last) begin
          restart_image();
          return;
        end
        col_q = col_q + 1'b1;
      end else begin
        held_q  = held_q | (tup_pkg::HeldW'(value) << (8 * phase_q));
        phase_q = phase_q + 1'b1;
      end
    end
    row_byte_q = row_byte_q + 1'b1;
    if (row_byte_q >= padded_row_bytes()) begin
      row_byte_q = '0;
      col_q      = '0;
      phase_q    = '0;
      held_q     = '0;
      row_q      = row_q + 1'b1;
      if (row_q >= height) row_q = '0;
    end
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: %s mismatch: got %0h, expected %0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && byte_if.valid && byte_if.ready) advance_packer(byte_if.data_byte);
  end

  always @(posedge clk_i) begin : texel_check
    texel_beat_t want;
    if (rst_ni && texel_if.valid && texel_if.ready) begin
      if (pending_texels.size() == 0) begin
        report_mismatch("unexpected texel", 32'(texel_if.texel), '0);
      end else begin
        want = pending_texels.pop_front();
        if (texel_if.texel !== want.texel)
          report_mismatch("texel", 32'(texel_if.texel), 32'(want.texel));
        if (texel_if.texel_index !== want.index)
          report_mismatch("texel_index", 32'(texel_if.texel_index), 32'(want.index));
        if (texel_if.last_texel !== want.last)
          report_mismatch("last_texel", 32'(texel_if.last_texel), 32'(want.last));
      end
    end
  end

  // Texel sink: random stalls, or a counted hold-off when one is requested.
  always @(posedge clk_i) begin
    if (hold_cycles_left > 0) begin
      hold_cycles_left = hold_cycles_left - 1;
      texel_if.ready <= 1'b0;
    end else begin
      texel_if.ready <= steady_flow || ($urandom_range(99) >= 33);
    end
  end

  task automatic send_byte(logic [tup_pkg::ByteW-1:0] value);
    while (!steady_flow && $urandom_range(99) < 33) begin
      byte_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    byte_if.valid     <= 1'b1;
    byte_if.data_byte <= value;
    do @(posedge clk_i); while (!byte_if.ready);
  endtask

  task automatic send_random_bytes(int unsigned count);
    repeat (count) send_byte(tup_pkg::ByteW'($urandom_range(255)));
  endtask

  // Padding bytes leave no trace in the texel queue, so once it is empty the
  // task waits further for them to clear the pipeline.
  task automatic wait_idle();
    byte_if.valid <= 1'b0;
    while (pending_texels.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(tup_pkg::cfg_reg_e idx, logic [tup_pkg::CfgDataW-1:0] value);
    wait_idle();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      tup_pkg::CFG_PIXEL_FORMAT:  fmt_q   = tup_pkg::pixel_format_e'(value[tup_pkg::FmtW-1:0]);
      tup_pkg::CFG_WIDTH_LOG2:    wlog_q  = value;
      tup_pkg::CFG_HEIGHT_LOG2:   hlog_q  = value;
      tup_pkg::CFG_ROW_ALIGNMENT: align_q = value;
      default: ;
    endcase
    restart_image();
  endtask

  task automatic configure(logic [tup_pkg::CfgDataW-1:0] fmt,
                           logic [tup_pkg::CfgDataW-1:0] wlog,
                           logic [tup_pkg::CfgDataW-1:0] hlog,
                           logic [tup_pkg::CfgDataW-1:0] align);
    write_reg(tup_pkg::CFG_PIXEL_FORMAT, fmt);
    write_reg(tup_pkg::CFG_WIDTH_LOG2, wlog);
    write_reg(tup_pkg::CFG_HEIGHT_LOG2, hlog);
    write_reg(tup_pkg::CFG_ROW_ALIGNMENT, align);
  endtask

  // One-texel images in each format.
  task automatic test_each_format();
    configure(tup_pkg::CfgDataW'(tup_pkg::FMT_RGB888), 4'd0, 4'd0, 4'd1);
    send_byte(8'hff);
    send_byte(8'h00);
    send_byte(8'hff);
    configure(tup_pkg::CfgDataW'(tup_pkg::FMT_RGB565), 4'd0, 4'd0, 4'd1);
    send_byte(8'h00);
    send_byte(8'hff);
    configure(tup_pkg::CfgDataW'(tup_pkg::FMT_RGBA8888), 4'd0, 4'd0, 4'd1);
    send_byte(8'hff);
    send_byte(8'h80);
    send_byte(8'h7f);
    send_byte(8'h80);
    configure(tup_pkg::CfgDataW'(tup_pkg::FMT_RGBA5551), 4'd0, 4'd0, 4'd1);
    send_byte(8'h01);
    send_byte(8'hfe);
  endtask

  // A two-byte row padded to three: the padding byte must give no texel.
  task automatic test_odd_padding();
    configure(tup_pkg::CfgDataW'(tup_pkg::FMT_RGB565), 4'd0, 4'd1, 4'd3);
    send_byte(8'h55);
    send_byte(8'haa);
    send_byte(8'hff);
    send_byte(8'h0f);
    send_byte(8'hf0);
  endtask

  // An alignment of zero behaves as no padding at all.
  task automatic test_zero_alignment();
    configure(tup_pkg::CfgDataW'(tup_pkg::FMT_RGB565), 4'd0, 4'd1, 4'd0);
    send_byte(8'h12);
    send_byte(8'h34);
    send_byte(8'hed);
    send_byte(8'hcb);
  endtask

  // A register write in the middle of a pixel throws the held bytes away.
  task automatic test_restart_mid_pixel();
    configure(tup_pkg::CfgDataW'(tup_pkg::FMT_RGB888), 4'd0, 4'd0, 4'd1);
    send_byte(8'hff);
    send_byte(8'hff);
    write_reg(tup_pkg::CFG_PIXEL_FORMAT, tup_pkg::CfgDataW'(tup_pkg::FMT_RGB565));
    send_byte(8'h34);
    send_byte(8'h12);
  endtask

  // A width beyond the maximum is clamped to it; the single row ends on the
  // last texel only if the clamp holds.
  task automatic test_oversized();
    configure(tup_pkg::CfgDataW'(tup_pkg::FMT_RGB565), 4'd15, 4'd0, 4'd2);
    send_random_bytes(image_bytes());
  endtask

  // The sink holds off long enough for the packer to fill and stall its input.
  task automatic test_backpressure();
    configure(tup_pkg::CfgDataW'(tup_pkg::FMT_RGB565), 4'd4, 4'd2, 4'd1);
    hold_cycles_left = 300;
    send_random_bytes(image_bytes());
  endtask

  // The source stops half way through the image until every texel is out.
  task automatic test_drain_pause();
    configure(tup_pkg::CfgDataW'(tup_pkg::FMT_RGBA5551), 4'd3, 4'd1, 4'd8);
    send_random_bytes(padded_row_bytes());
    wait_idle();
    send_random_bytes(image_bytes() - padded_row_bytes());
  endtask

  task automatic test_steady_flow();
    configure(tup_pkg::CfgDataW'(tup_pkg::FMT_RGB888), 4'd2, 4'd2, 4'd4);
    steady_flow = 1'b1;
    send_random_bytes(2 * image_bytes());
    wait_idle();
    steady_flow = 1'b0;
  endtask

  // Mostly whole images under random settings; now and then an image is cut
  // short and the next register write starts afresh.
  task automatic test_random_images();
    int unsigned sent;
    int unsigned count;
    logic [tup_pkg::CfgDataW-1:0] wlog;
    logic [tup_pkg::CfgDataW-1:0] hlog;
    logic [tup_pkg::CfgDataW-1:0] align;
    sent = 0;
    while (sent < RandomItems) begin
      if ($urandom_range(15) == 0) begin
        wlog = tup_pkg::CfgDataW'($urandom_range(4, 6));
        hlog = tup_pkg::CfgDataW'($urandom_range(0, 1));
      end else begin
        wlog = tup_pkg::CfgDataW'($urandom_range(0, 3));
        hlog = tup_pkg::CfgDataW'($urandom_range(0, 3));
      end
      if ($urandom_range(1) == 1) begin
        align = tup_pkg::CfgDataW'(1 << $urandom_range(0, 3));
      end else begin
        align = tup_pkg::CfgDataW'($urandom_range(0, 15));
      end
      configure(tup_pkg::CfgDataW'($urandom_range(0, 15)), wlog, hlog, align);
      repeat ($urandom_range(1, 3)) begin
        send_random_bytes(image_bytes());
        sent += image_bytes();
      end
      if ($urandom_range(4) == 0 && image_bytes() > 1) begin
        count = $urandom_range(1, image_bytes() - 1);
        send_random_bytes(count);
        sent += count;
      end
    end
  endtask

  initial begin
    rst_ni            <= 1'b0;
    cfg_we_i          <= 1'b0;
    cfg_idx_i         <= tup_pkg::CFG_PIXEL_FORMAT;
    cfg_data_i        <= '0;
    byte_if.valid     <= 1'b0;
    byte_if.data_byte <= '0;
    fmt_q   = tup_pkg::FMT_RGB888;
    wlog_q  = '0;
    hlog_q  = '0;
    align_q = tup_pkg::AlignReset;
    restart_image();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_each_format();
    test_odd_padding();
    test_zero_alignment();
    test_restart_mid_pixel();
    test_oversized();
    test_backpressure();
    test_drain_pause();
    test_steady_flow();
    test_random_images();

    wait_idle();
    if (mismatch_count == 0) begin
      $display("texture_upload_texel_packer_unit_tb passed");
    end else begin
      $display("texture_upload_texel_packer_unit_tb failed");
    end
    $finish;
  end

endmodule : texture_upload_texel_packer_unit_tb
